/* rtl/wbps_pkg.sv */
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants of the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int CFG_BYTES       = 16;
  localparam int CFG_IDX_W       = $clog2(CFG_BYTES);
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_LEN_W       = 5;
  localparam int CFG_INDEX_W     = 2;
  localparam int ADDR_W          = 32;
  localparam int IN_TDATA_W      = 40;
  localparam int IN_TUSER_W      = 2;
  localparam int OUT_TDATA_W     = 32;
  localparam int OUT_TUSER_W     = 2;

  localparam logic [7:0] WILDCARD_BYTE = 8'hFF;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_FIRST  = 2'd0,
    REG_PATTERN_SECOND = 2'd1,
    REG_PATTERN_LENGTH = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_BYTES-1:0][7:0] pattern;
    logic [CFG_LEN_W-1:0]      length;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic [ADDR_W-1:0] byte_address;
    logic              new_search;
    logic              after_gap;
    logic              last_byte;
  } item_t;

  typedef struct packed {
    logic              match_found;
    logic [ADDR_W-1:0] match_address;
    logic              search_failed;
  } result_t;

endpackage

/* rtl/wbps_cfg_regs.sv */
// ----------------------------------------------------------------------------
// wbps_cfg_regs
// Pattern and length registers, written through the plain write port.
// ----------------------------------------------------------------------------
module wbps_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [wbps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output wbps_pkg::cfg_t                   cfg
);
  import wbps_pkg::*;

  logic [CFG_DATA_W-1:0] pattern_first;
  logic [CFG_DATA_W-1:0] pattern_second;
  logic [CFG_LEN_W-1:0]  pattern_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_first  <= '0;
      pattern_second <= '0;
      pattern_length <= CFG_LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_FIRST:  pattern_first  <= cfg_wdata;
        REG_PATTERN_SECOND: pattern_second <= cfg_wdata;
        REG_PATTERN_LENGTH: pattern_length <= cfg_wdata[CFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.pattern = {pattern_second, pattern_first};
  assign cfg.length  = pattern_length;

endmodule

/* rtl/wbps_in_stage.sv */
// ----------------------------------------------------------------------------
// wbps_in_stage
// Input register holding one request until the match stage takes it.
// ----------------------------------------------------------------------------
module wbps_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  wbps_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_take,
  output wbps_pkg::item_t out_item
);
  import wbps_pkg::*;

  logic held;
  item_t item;

  // free when empty or when the held request leaves this cycle
  assign in_ready = !held || out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (out_take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

  assign out_valid = held;
  assign out_item  = item;

endmodule

/* rtl/wbps_match_core.sv */
// ----------------------------------------------------------------------------
// wbps_match_core
// Byte history, parallel wildcard compare against all pattern positions,
// fill count and match lock.
// ----------------------------------------------------------------------------
module wbps_match_core #(
  parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  wbps_pkg::item_t   item,
  input  wbps_pkg::cfg_t    cfg,
  output wbps_pkg::result_t result
);
  import wbps_pkg::*;

  localparam int CAP    = (PATTERN_MAX < CFG_BYTES) ? PATTERN_MAX : CFG_BYTES;
  localparam int HIST   = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
  localparam int LEN_W  = $clog2(CAP + 1);
  localparam int FILL_W = $clog2(HIST + 1);
  localparam int CMP_W  = ((LEN_W > FILL_W) ? LEN_W : FILL_W) + 1;

  logic [7:0]        history [HIST];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic              locked;
  logic              locked_next;

  logic [LEN_W-1:0]  len;
  logic              clear;
  logic [FILL_W-1:0] fill_eff;
  logic              locked_eff;
  logic [7:0]        window [CAP];
  logic [CAP-1:0]    pos_ok;
  logic              enough;
  logic              hit;

  // zero length acts as one, anything above the cap is clipped
  always_comb begin
    if (cfg.length == '0) begin
      len = LEN_W'(1);
    end else if (int'(cfg.length) > CAP) begin
      len = LEN_W'(CAP);
    end else begin
      len = LEN_W'(cfg.length);
    end
  end

  assign clear      = item.new_search | item.after_gap;
  assign fill_eff   = clear ? '0 : fill;
  assign locked_eff = item.new_search ? 1'b0 : locked;

  // window slot 0 is the new byte, slot j is the byte j requests back
  always_comb begin
    window[0] = item.data_byte;
    for (int j = 1; j < CAP; j++) begin
      window[j] = history[j-1];
    end
  end

  // slot j is checked against pattern byte len-1-j
  always_comb begin : pos_cmp
    logic [LEN_W-1:0] pk;
    logic [7:0]       pb;
    for (int j = 0; j < CAP; j++) begin
      pk = len - LEN_W'(1) - LEN_W'(j);
      pb = cfg.pattern[CFG_IDX_W'(pk)];
      if (LEN_W'(j) < len) begin
        pos_ok[j] = (pb == WILDCARD_BYTE) || (pb == window[j]);
      end else begin
        pos_ok[j] = 1'b1;
      end
    end
  end

  assign enough = (CMP_W'(fill_eff) + CMP_W'(1)) >= CMP_W'(len);
  assign hit    = !locked_eff && enough && (&pos_ok);

  assign result.match_found   = hit;
  assign result.match_address = hit ? (item.byte_address - (ADDR_W'(len) - ADDR_W'(1)))
                                    : '0;
  assign result.search_failed = item.last_byte && !hit && !locked_eff;

  assign fill_next   = (fill_eff < FILL_W'(HIST)) ? fill_eff + FILL_W'(1) : fill_eff;
  assign locked_next = locked_eff | hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      locked <= 1'b0;
    end else if (advance) begin
      fill   <= fill_next;
      locked <= locked_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      history[0] <= item.data_byte;
      for (int i = 1; i < HIST; i++) begin
        history[i] <= history[i-1];
      end
    end
  end

endmodule

/* rtl/wildcard_byte_pattern_scan.sv */
// A request is accepted into the input register and its result is captured in the result register.
// Throughput: one byte per cycle while the result register is not stalled; the compare
// against the history and the history shift both finish in the match stage.
// A stalled result holds the next request in the input register, which then blocks s_tready.
// Reset (rst, synchronous) clears the fill count, the lock, both pipeline
// valid flags and sets the pattern to all zeros with length one.
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// Stream scanner for the first occurrence of a wildcard byte pattern.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan #(
  parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // data_byte [7:0], byte_address [39:8]
  input  logic [wbps_pkg::IN_TDATA_W-1:0]  s_tdata,
  // new_search [0], after_gap [1]
  input  logic [wbps_pkg::IN_TUSER_W-1:0]  s_tuser,
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // match_address [31:0]
  output logic [wbps_pkg::OUT_TDATA_W-1:0] m_tdata,
  // match_found [0], search_failed [1]
  output logic [wbps_pkg::OUT_TUSER_W-1:0] m_tuser,
  input  logic                             cfg_we,
  input  logic [wbps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import wbps_pkg::*;

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    take;
  cfg_t    cfg;
  result_t result;
  result_t out_result;

  assign in_item.data_byte    = s_tdata[7:0];
  assign in_item.byte_address = s_tdata[IN_TDATA_W-1:8];
  assign in_item.new_search   = s_tuser[0];
  assign in_item.after_gap    = s_tuser[1];
  assign in_item.last_byte    = s_tlast;

  assign take = s1_valid && (!m_tvalid || m_tready);

  wbps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  wbps_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .out_valid (s1_valid),
    .out_take  (take),
    .out_item  (s1_item)
  );

  wbps_match_core #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (take),
    .item    (s1_item),
    .cfg     (cfg),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_result <= result;
    end
  end

  assign m_tdata = out_result.match_address;
  assign m_tuser = {out_result.search_failed, out_result.match_found};

`ifndef NO_ASSERTIONS
  a_found_xor_failed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("match and failure reported together");

  a_addr_zero_no_match: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("match address nonzero without a match");

  a_s1_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !take) |=> s1_valid)
    else $error("input stage request dropped");

  a_take_shows_result: assert property (@(posedge clk) disable iff (rst)
    take |=> m_tvalid)
    else $error("processed request produced no result");
`endif

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the wildcard byte pattern scanner. Directed byte
// runs cover address wrap, gaps, locking and flags. Random searches follow,
// under a series of pattern settings, with the pattern often planted in them.
// Each request is predicted at acceptance and each result is checked in order.
// ----------------------------------------------------------------------------
module testbench;
  import wbps_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  wildcard_byte_pattern_scan i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial forever #1 clk = ~clk;

  initial begin
    #400000;
    $display("wildcard_byte_pattern_scan: mismatch");
    $finish;
  end

  // shadow of the scanner configuration and state
  logic [63:0] pat_lo = '0;
  logic [63:0] pat_hi = '0;
  logic [4:0]  pat_len = 5'd1;
  logic [7:0]  hist [0:14] = '{default: 8'h00};
  int          hist_fill = 0;
  bit          match_lock = 1'b0;

  item_t   byte_requests [$];
  result_t expected_results [$];
  item_t   offered;
  result_t want;
  int      errors = 0;
  int      results_seen = 0;
  int      queued_count = 0;
  int      hold_left = 0;
  bit      hold_done = 1'b0;
  logic    idling_on;

  // one quiet stretch with no idling on either side
  assign idling_on = !(results_seen >= 600 && results_seen < 800);

  function automatic int scan_len();
    int n;
    n = pat_len;
    if (n == 0) n = 1;
    if (n > 16) n = 16;
    return n;
  endfunction

  function automatic logic [7:0] pat_byte(input int k);
    if (k < 8) return pat_lo[8*k +: 8];
    return pat_hi[8*(k-8) +: 8];
  endfunction

  function automatic bit byte_ok(input int k, input logic [7:0] d);
    return pat_byte(k) == WILDCARD_BYTE || pat_byte(k) == d;
  endfunction

  function automatic void scan_predict(input item_t it);
    result_t r;
    int      n;
    bit      hit;
    n = scan_len();
    if (it.new_search || it.after_gap) begin
      hist = '{default: 8'h00};
      hist_fill = 0;
    end
    if (it.new_search) match_lock = 1'b0;
    hit = 1'b0;
    if (!match_lock && hist_fill + 1 >= n) begin
      hit = byte_ok(n - 1, it.data_byte);
      // hist[0] is the newest byte, so pattern byte k sits at n-2-k
      for (int k = 0; k < n - 1; k++)
        if (hit) hit = byte_ok(k, hist[n-2-k]);
    end
    for (int i = 14; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = it.data_byte;
    if (hist_fill < 15) hist_fill++;
    r.match_found   = hit;
    r.match_address = hit ? it.byte_address - (n - 1) : '0;
    r.search_failed = it.last_byte && !hit && !match_lock;
    if (hit) match_lock = 1'b1;
    expected_results.push_back(r);
  endfunction

  // request side
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) scan_predict(offered);
      if (!s_tvalid || s_tready) begin
        if (byte_requests.size() > 0 && !(idling_on && $urandom_range(99) < 6)) begin
          offered = byte_requests.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {offered.byte_address, offered.data_byte};
          s_tuser  <= {offered.after_gap, offered.new_search};
          s_tlast  <= offered.last_byte;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: tdata %h tuser %b", m_tdata, m_tuser);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (m_tuser[0] !== want.match_found) begin
            $error("match_found: expected %0b, got %0b", want.match_found, m_tuser[0]);
            errors++;
          end
          if (m_tdata !== want.match_address) begin
            $error("match_address: expected %h, got %h", want.match_address, m_tdata);
            errors++;
          end
          if (m_tuser[1] !== want.search_failed) begin
            $error("search_failed: expected %0b, got %0b", want.search_failed, m_tuser[1]);
            errors++;
          end
        end
      end
      // one long hold-off so the pipeline backs up into the request side
      if (!hold_done && results_seen >= 400) begin
        hold_done = 1'b1;
        hold_left = 90;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(idling_on && $urandom_range(99) < 6);
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PATTERN_FIRST:  pat_lo = val;
      REG_PATTERN_SECOND: pat_hi = val;
      REG_PATTERN_LENGTH: pat_len = val[4:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (byte_requests.size() != 0 || expected_results.size() != 0 || s_tvalid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_byte(input logic [7:0] d, input logic [31:0] a,
                          input bit fresh, input bit gap, input bit last);
    item_t it;
    it.data_byte    = d;
    it.byte_address = a;
    it.new_search   = fresh;
    it.after_gap    = gap;
    it.last_byte    = last;
    byte_requests.push_back(it);
    queued_count++;
  endtask

  function automatic logic [63:0] rand_pattern(input int wild_pct);
    logic [63:0] v;
    for (int i = 0; i < 8; i++)
      v[8*i +: 8] = ($urandom_range(99) < wild_pct) ? WILDCARD_BYTE : 8'($urandom);
    return v;
  endfunction

  // one well-formed search, usually with the pattern planted somewhere
  task automatic add_search();
    logic [31:0] base;
    logic [7:0]  pb;
    int          n;
    int          count;
    int          extra;
    int          plant_at;
    n = scan_len();
    count = $urandom_range(1, 2 * n + 8);
    extra = ($urandom_range(7) == 0) ? $urandom_range(1, 4) : 0;
    base = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF - $urandom_range(24) : $urandom;
    plant_at = ($urandom_range(3) == 0) ? -1 : $urandom_range(0, count - 1);
    for (int i = 0; i < count + extra; i++) begin
      if (plant_at >= 0 && i >= plant_at && i < plant_at + n)
        pb = pat_byte(i - plant_at);
      else if ($urandom_range(1))
        pb = pat_byte($urandom_range(0, n - 1));
      else
        pb = WILDCARD_BYTE;
      add_byte((pb == WILDCARD_BYTE) ? 8'($urandom) : pb, base + i, i == 0,
               (i == 0) ? ($urandom_range(3) == 0) : ($urandom_range(39) == 0),
               i == count - 1);
    end
  endtask

  // fill to the target, with a full drain halfway so the sender pauses
  task automatic run_phase(input int target);
    int goal;
    for (int half = 1; half <= 2; half++) begin
      goal = queued_count + target / 2;
      while (queued_count < goal) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1, 6))
            add_byte(8'($urandom), $urandom, $urandom_range(7) == 0,
                     $urandom_range(7) == 0, $urandom_range(7) == 0);
        end else begin
          add_search();
        end
      end
      drain();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset pattern: a single zero byte
    add_byte(8'h00, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
    add_byte(8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1);
    drain();

    // pattern a1, any, 5c
    write_reg(REG_PATTERN_FIRST, 64'h0000_0000_005C_FFA1);
    write_reg(REG_PATTERN_SECOND, 64'h0);
    write_reg(REG_PATTERN_LENGTH, 64'd3);
    // match start wraps below address zero, then stays locked past the last byte
    add_byte(8'hA1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    add_byte(8'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
    add_byte(8'h5C, 32'h0000_0001, 1'b0, 1'b0, 1'b0);
    add_byte(8'hA1, 32'h0000_0002, 1'b0, 1'b0, 1'b0);
    add_byte(8'hFF, 32'h0000_0003, 1'b0, 1'b0, 1'b0);
    add_byte(8'h5C, 32'h0000_0004, 1'b0, 1'b0, 1'b1);
    add_byte(8'hA1, 32'h0000_0005, 1'b0, 1'b0, 1'b0);
    // both flags together, then a gap that splits a match
    add_byte(8'hA1, 32'd100, 1'b1, 1'b1, 1'b0);
    add_byte(8'h33, 32'd101, 1'b0, 1'b0, 1'b0);
    add_byte(8'h5C, 32'd102, 1'b0, 1'b1, 1'b0);
    add_byte(8'hA1, 32'd103, 1'b0, 1'b0, 1'b0);
    add_byte(8'hA1, 32'd104, 1'b0, 1'b0, 1'b0);
    add_byte(8'hFF, 32'd105, 1'b0, 1'b0, 1'b1);
    // scanning goes on after the last byte
    add_byte(8'h5C, 32'd106, 1'b0, 1'b0, 1'b0);
    // match on the last byte, then a one-byte search that is too short
    add_byte(8'hA1, 32'hFFFF_FFFE, 1'b1, 1'b0, 1'b0);
    add_byte(8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
    add_byte(8'h5C, 32'h0000_0000, 1'b0, 1'b0, 1'b1);
    add_byte(8'h00, 32'h0000_0000, 1'b1, 1'b0, 1'b1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          // all wildcards at full length
          write_reg(REG_PATTERN_FIRST, '1);
          write_reg(REG_PATTERN_SECOND, '1);
          write_reg(REG_PATTERN_LENGTH, 64'd16);
        end
        1: begin
          // zero length acts as one
          write_reg(REG_PATTERN_FIRST, rand_pattern(0));
          write_reg(REG_PATTERN_SECOND, 64'h0);
          write_reg(REG_PATTERN_LENGTH, 64'd0);
        end
        2: begin
          // oversized length clamps to sixteen
          write_reg(REG_PATTERN_FIRST, rand_pattern(25));
          write_reg(REG_PATTERN_SECOND, rand_pattern(25));
          write_reg(REG_PATTERN_LENGTH, 64'h1F);
        end
        3: begin
          write_reg(REG_PATTERN_FIRST, rand_pattern(0));
          write_reg(REG_PATTERN_SECOND, rand_pattern(0));
          write_reg(REG_PATTERN_LENGTH, 64'd17);
        end
        default: begin
          write_reg(REG_PATTERN_FIRST, rand_pattern(25));
          write_reg(REG_PATTERN_SECOND, rand_pattern(25));
          write_reg(REG_PATTERN_LENGTH, ($urandom_range(3) == 0) ?
                    64'($urandom_range(0, 31)) : 64'($urandom_range(1, 6)));
        end
      endcase
      run_phase(116);
    end

    drain();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("wildcard_byte_pattern_scan: match");
    end else begin
      $display("wildcard_byte_pattern_scan: mismatch");
    end
    $finish;
  end

endmodule
